// File: hw/rtl/gradient_l2_norm_clip_defines.svh
// Assertion macros for the gradient clipping block.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef GRADIENT_L2_NORM_CLIP_DEFINES_SVH
`define GRADIENT_L2_NORM_CLIP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gradient_l2_norm_clip: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gradient_l2_norm_clip: assertion failed");
`else
`define GC_ASSERT_IMPL(lbl, ante, cons)
`define GC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/gclip_pkg.sv
// Shared constants and controller/datapath interface types for gradient clipping.
// No dependencies.
package gclip_pkg;

    localparam int GRAD_W           = 16;
    localparam int NORM_W           = 20;
    localparam int SUM_W            = 37;
    localparam int ROOT_W           = 19;
    localparam int RAD_W            = 2 * ROOT_W;
    localparam int SREM_W           = ROOT_W + 2;
    localparam int SCALE_W          = 16;
    localparam int SQRT_STEPS       = ROOT_W;
    localparam int DIV_STEPS        = SCALE_W;
    localparam int STEP_W           = 5;
    localparam int MAX_ELEMENTS_DEF = 64;

    localparam logic [NORM_W-1:0] MAX_NORM_RST = NORM_W'(4096);

    typedef struct packed {
        logic load;       // element transaction accepted
        logic sqrt_init;  // load root unit from the running sum
        logic sqrt_step;  // one root digit
        logic div_init;   // latch clip decision, load divider
        logic div_step;   // one quotient bit
        logic fetch;      // read the first stored element
        logic fill;       // load the output register from read data
        logic advance;    // result transaction accepted
        logic clear;      // vector done, drop sum, count and flag
    } cmd_t;

    typedef struct packed {
        logic norm_gt;    // norm above threshold
        logic emit_last;  // current output index is the final element
    } sts_t;

endpackage

// File: hw/rtl/gclip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gclip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/gclip_dp.sv
// Datapath: element buffer, sum of squares, bit-serial square root,
// restoring divider for the scale, and the output multiplier. Uses gclip_pkg, gclip_ram.
module gclip_dp import gclip_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              cfg_valid,
    input  logic [NORM_W-1:0] cfg_data,
    input  logic [GRAD_W-1:0] s_grad_in,
    output logic [GRAD_W-1:0] m_grad_out,
    output logic              m_last_out,
    output logic              m_was_clipped,
    output logic              m_overflow
);

    localparam int COUNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int AW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [NORM_W-1:0]  max_norm_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               dropped_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [COUNT_W-1:0] idx_inc;

    logic [RAD_W-1:0]   rad_reg;
    logic [SREM_W-1:0]  srem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W-1:0]  drem_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               clip_reg;

    logic [GRAD_W-1:0]  grad_out_reg;
    logic               last_out_reg;
    logic               clip_out_reg;
    logic               ovf_out_reg;

    logic               full;
    logic [GRAD_W:0]    in_mag;
    logic [2*GRAD_W+1:0] in_sq;

    logic [SREM_W+1:0]  srem_sh;
    logic [SREM_W+1:0]  trial;
    logic               sqrt_ge;
    logic [ROOT_W:0]    drem_sh;
    logic               div_ge;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [GRAD_W-1:0]  rd_data;
    logic               e_neg;
    logic [GRAD_W:0]    e_mag;
    logic [GRAD_W+SCALE_W:0] prod;
    logic [GRAD_W+SCALE_W:0] prod_rnd;
    logic [GRAD_W:0]    p_mag;
    logic [GRAD_W-1:0]  scaled;

    assign full    = (count_reg == COUNT_W'(MAX_ELEMENTS));
    assign idx_inc = COUNT_W'(idx_reg + 1'b1);

    // Magnitude and square of the incoming element
    assign in_mag = s_grad_in[GRAD_W-1] ? (GRAD_W+1)'(-$signed({s_grad_in[GRAD_W-1], s_grad_in}))
                                        : {1'b0, s_grad_in};
    assign in_sq  = in_mag * in_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_norm_reg <= MAX_NORM_RST;
            sum_reg      <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_norm_reg <= cfg_data;
            end
            if (cmd.clear) begin
                sum_reg     <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (cmd.load) begin
                if (full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    sum_reg   <= SUM_W'(sum_reg + SUM_W'(in_sq));
                    count_reg <= COUNT_W'(count_reg + 1'b1);
                end
            end
        end
    end

    gclip_ram #(
        .WIDTH (GRAD_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.load && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_grad_in),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Square root, one result bit per step: bring down two radicand bits
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = (SREM_W+2)'({root_reg, 2'b01});
    assign sqrt_ge = (srem_sh >= trial);

    // Quotient bit of (max_norm << 16) / norm
    assign drem_sh = {drem_reg, 1'b0};
    assign div_ge  = (drem_sh >= {1'b0, root_reg});

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg  <= RAD_W'(sum_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (sqrt_ge) begin
                srem_reg <= SREM_W'(srem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= SREM_W'(srem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init) begin
            clip_reg  <= sts.norm_gt;
            drem_reg  <= max_norm_reg[ROOT_W-1:0];
            scale_reg <= '0;
        end else if (cmd.div_step) begin
            if (div_ge) begin
                drem_reg <= ROOT_W'(drem_sh - {1'b0, root_reg});
            end else begin
                drem_reg <= drem_sh[ROOT_W-1:0];
            end
            scale_reg <= {scale_reg[SCALE_W-2:0], div_ge};
        end
    end

    assign sts.norm_gt   = ({1'b0, root_reg} > max_norm_reg);
    assign sts.emit_last = (idx_inc == count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            idx_reg <= '0;
        end else if (cmd.advance) begin
            idx_reg <= idx_inc;
        end
    end

    // Prefetch the next element while the current result is taken
    assign rd_en   = cmd.fetch || (cmd.advance && !sts.emit_last);
    assign rd_addr = cmd.fetch ? idx_reg[AW-1:0] : idx_inc[AW-1:0];

    // Scale by Q0.16, round half away from zero on the magnitude
    assign e_neg    = rd_data[GRAD_W-1];
    assign e_mag    = e_neg ? (GRAD_W+1)'(-$signed({rd_data[GRAD_W-1], rd_data}))
                            : {1'b0, rd_data};
    assign prod     = e_mag * scale_reg;
    assign prod_rnd = prod + (GRAD_W+SCALE_W+1)'(1 << (SCALE_W - 1));
    assign p_mag    = prod_rnd[GRAD_W+SCALE_W -: GRAD_W+1];
    assign scaled   = e_neg ? GRAD_W'(-p_mag) : p_mag[GRAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            grad_out_reg <= clip_reg ? scaled : rd_data;
            last_out_reg <= sts.emit_last;
            clip_out_reg <= clip_reg;
            ovf_out_reg  <= dropped_reg;
        end
    end

    assign m_grad_out    = grad_out_reg;
    assign m_last_out    = last_out_reg;
    assign m_was_clipped = clip_out_reg;
    assign m_overflow    = ovf_out_reg;

endmodule

// File: hw/rtl/gclip_ctrl.sv
// Controller: sequences load, root, divide and emission phases.
// Uses gclip_pkg; drives the datapath through cmd_t, reads sts_t.
module gclip_ctrl import gclip_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_last_in,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RINIT = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;
    localparam logic [2:0] ST_FILL  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_in) begin
                        state_next = ST_RINIT;
                    end
                end
            end
            ST_RINIT: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = sts.norm_gt ? ST_DIV : ST_FETCH;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd.fill   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    if (sts.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);

endmodule

// File: hw/rtl/gradient_l2_norm_clip.sv
// Gradient clipping by L2 norm: top level joining controller and datapath.
// Uses gclip_pkg, gclip_ctrl, gclip_dp (with gclip_ram), and the assertion macro header.
//
// Usage:
//   s_ channel takes one signed Q4.12 element per transaction, s_last_in on the
//   final one. Elements arrive at one per cycle while s_ready is high; those
//   beyond MAX_ELEMENTS are dropped and reported through m_overflow.
//   After the last element the block computes the norm with a bit-serial
//   square root (an init step, one step per root bit, then a compare) and, if
//   the norm is above max_norm, the Q0.16 scale with a restoring divider.
//   The m_ channel then returns every stored element, one at a time
//   (fill the output register, then hand over; the next element is read
//   during the handover). m_last_out marks the final result.
//   A stalled receiver holds the output register; nothing advances until the
//   result transaction completes. s_ready stays low from the last element
//   until the last result is taken.
//   cfg_ data writes max_norm (unsigned Q8.12); cfg_ready is always high.
//   Write it only between vectors. Reset sets max_norm to 1.0 and empties
//   the vector; buffer contents are not cleared.
`include "gradient_l2_norm_clip_defines.svh"

module gradient_l2_norm_clip import gclip_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NORM_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [GRAD_W-1:0] s_grad_in,
    input  logic              s_last_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [GRAD_W-1:0] m_grad_out,
    output logic              m_last_out,
    output logic              m_was_clipped,
    output logic              m_overflow
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gclip_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last_in (s_last_in),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gclip_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_grad_in     (s_grad_in),
        .m_grad_out    (m_grad_out),
        .m_last_out    (m_last_out),
        .m_was_clipped (m_was_clipped),
        .m_overflow    (m_overflow)
    );

    // Loading and emitting never overlap
    `GC_ASSERT_IMPL(a_no_overlap, s_ready, !m_valid)
    // The final element closes the input side until emission is over
    `GC_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last_in, !s_ready)
    // Taking the final result reopens the input side at once
    `GC_ASSERT_NEXT(a_ready_after_last, m_valid && m_ready && m_last_out, s_ready)
    // At most one datapath phase is active in a cycle
    `GC_ASSERT_IMPL(a_cmd_excl, 1'b1,
        $onehot0({cmd.load, cmd.sqrt_step, cmd.div_step, cmd.fill, cmd.advance}))

endmodule

// File: verif/gradient_l2_norm_clip_checker.sv
// Checker for the gradient clipping block: observes the cfg_, s_ and m_ channels,
// predicts each clipped element, and compares the results. Depends on gclip_pkg.
module gradient_l2_norm_clip_checker import gclip_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [NORM_W-1:0] cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [GRAD_W-1:0] s_grad_in,
    input  logic              s_last_in,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [GRAD_W-1:0] m_grad_out,
    input  logic              m_last_out,
    input  logic              m_was_clipped,
    input  logic              m_overflow,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [GRAD_W-1:0] grad;
        logic              last;
        logic              clipped;
        logic              overflow;
    } clip_result_t;

    clip_result_t      clipped_q[$];
    logic [GRAD_W-1:0] elem_buf[MAX_ELEMENTS];
    logic [SUM_W-1:0]  sq_sum;
    int unsigned       elem_cnt;
    logic              dropped;
    logic [NORM_W-1:0] max_norm_q;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Absorb one element; on the last one, queue the whole result vector, scaled when clipped.
    task automatic take_element(input logic [GRAD_W-1:0] g, input logic is_last);
        longint          gv;
        longint          ev;
        longint unsigned mag;
        longint unsigned norm;
        longint unsigned scale;
        longint unsigned prod;
        logic            clip;
        clip_result_t    r;
        int unsigned     i;
        gv = longint'($signed(g));
        if (elem_cnt < MAX_ELEMENTS) begin
            elem_buf[elem_cnt] = g;
            mag = (gv < 0) ? -gv : gv;
            sq_sum = sq_sum + SUM_W'(mag * mag);
            elem_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!is_last)
            return;

        norm  = floor_sqrt(longint'(sq_sum));
        clip  = norm > longint'(max_norm_q);
        scale = clip ? ((longint'(max_norm_q) << 16) / norm) : 0;
        for (i = 0; i < elem_cnt; i++) begin
            ev = longint'($signed(elem_buf[i]));
            if (clip) begin
                mag  = (ev < 0) ? -ev : ev;
                prod = (mag * scale + 64'h8000) >> 16;
                ev   = (ev < 0) ? -longint'(prod) : longint'(prod);
            end
            r.grad     = ev[GRAD_W-1:0];
            r.last     = (i == elem_cnt - 1);
            r.clipped  = clip;
            r.overflow = dropped;
            clipped_q.push_back(r);
        end
        sq_sum   = '0;
        elem_cnt = 0;
        dropped  = 1'b0;
    endtask

    always @(posedge aclk) begin
        clip_result_t want;
        if (!aresetn) begin
            clipped_q.delete();
            sq_sum     = '0;
            elem_cnt   = 0;
            dropped    = 1'b0;
            max_norm_q = MAX_NORM_RST;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (clipped_q.size() == 0) begin
                    $error("unexpected result transaction: grad_out %0d",
                           $signed(m_grad_out));
                    fail_count++;
                end else begin
                    want = clipped_q.pop_front();
                    if (m_grad_out !== want.grad) begin
                        $error("grad_out: expected %0d, got %0d",
                               $signed(want.grad), $signed(m_grad_out));
                        fail_count++;
                    end
                    if (m_last_out !== want.last) begin
                        $error("last_out: expected %0d, got %0d", want.last, m_last_out);
                        fail_count++;
                    end
                    if (m_was_clipped !== want.clipped) begin
                        $error("was_clipped: expected %0d, got %0d",
                               want.clipped, m_was_clipped);
                        fail_count++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, m_overflow);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                max_norm_q = cfg_data;
            if (s_valid && s_ready)
                take_element(s_grad_in, s_last_in);
        end
        pending <= clipped_q.size();
    end

endmodule

// File: verif/gradient_l2_norm_clip_tb.sv
// Testbench top for gradient_l2_norm_clip: drives vectors, threshold writes and
// back-pressure. Depends on gclip_pkg, the block RTL and gradient_l2_norm_clip_checker.
module gradient_l2_norm_clip_tb;
    import gclip_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 30;
    localparam int NUM_PHASES     = 8;

    logic              aclk      = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NORM_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [GRAD_W-1:0] s_grad_in;
    logic              s_last_in;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [GRAD_W-1:0] m_grad_out;
    logic              m_last_out;
    logic              m_was_clipped;
    logic              m_overflow;

    int fail_count;
    int pending;
    int src_idle   = 0;
    int sink_stall = 0;
    int quiet_cycles;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    gradient_l2_norm_clip DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_grad_in     (s_grad_in),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grad_out    (m_grad_out),
        .m_last_out    (m_last_out),
        .m_was_clipped (m_was_clipped),
        .m_overflow    (m_overflow)
    );

    gradient_l2_norm_clip_checker clip_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_grad_in     (s_grad_in),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grad_out    (m_grad_out),
        .m_last_out    (m_last_out),
        .m_was_clipped (m_was_clipped),
        .m_overflow    (m_overflow),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall);
    end

    // End the run when no transaction moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Leaves s_valid high on return; the caller lowers it after the last element.
    task automatic push_element(input logic [GRAD_W-1:0] g, input logic is_last);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_grad_in <= g;
        s_last_in <= is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [GRAD_W-1:0] pick_element(input int flavor);
        int sel;
        case (flavor)
            0: return GRAD_W'($urandom_range(0, 65535));
            1: return GRAD_W'(int'($urandom_range(0, 1023)) - 512);
            default: begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_vector(input int len, input int flavor);
        int i;
        for (i = 0; i < len; i++)
            push_element(pick_element(flavor), i == len - 1);
    endtask

    // Hold until every queued result is back, then let the block settle.
    task automatic drain();
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_norm(input logic [NORM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int items;
        int len;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_grad_in <= '0;
        s_last_in <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed vectors at the reset threshold of 1.0.
        push_element(16'h7FFF, 1'b1);
        push_element(16'h8000, 1'b1);
        push_element(16'h0000, 1'b1);
        push_element(16'd4096, 1'b1);     // norm equals threshold: no clip
        push_element(16'd4097, 1'b1);     // just above threshold
        push_element(16'h0001, 1'b0);
        push_element(16'hFFFF, 1'b0);
        push_element(16'h8000, 1'b0);
        push_element(16'h7FFF, 1'b1);
        push_element(16'h1000, 1'b0);
        push_element(16'hF000, 1'b1);
        s_valid <= 1'b0;
        drain();

        // Zero threshold: a zero vector passes, anything else scales to zero.
        set_max_norm('0);
        push_element(16'h0000, 1'b1);
        push_element(16'h0001, 1'b0);
        push_element(16'hFFFF, 1'b1);
        s_valid <= 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: set_max_norm('0);
                1: set_max_norm({NORM_W{1'b1}});
                2: set_max_norm(NORM_W'($urandom_range(0, 65535)));
                3: set_max_norm(NORM_W'($urandom_range(0, 262143)));
                4: set_max_norm(NORM_W'(1));
                5: set_max_norm(NORM_W'($urandom_range(0, 1048575)));
                6: set_max_norm(NORM_W'($urandom_range(4096, 40000)));
                default: set_max_norm(NORM_W'($urandom_range(0, 131071)));
            endcase
            case (ph % 4)
                0: begin
                    src_idle   = 0;
                    sink_stall = 0;
                end
                1: begin
                    src_idle   = 54;
                    sink_stall = 0;
                end
                2: begin
                    src_idle   = 0;
                    sink_stall = 54;
                end
                default: begin
                    src_idle   = 26;
                    sink_stall = 26;
                end
            endcase
            items = 0;
            while (items < PHASE_ITEMS) begin
                // Open some phases with a full or overfull vector.
                if (items == 0 && ph == 2)
                    len = MAX_ELEMENTS_DEF + 4;
                else if (items == 0 && ph == 5)
                    len = MAX_ELEMENTS_DEF;
                else if (items == 0 && ph == 7)
                    len = MAX_ELEMENTS_DEF + 2;
                else
                    len = $urandom_range(1, 12);
                send_vector(len, $urandom_range(0, 2));
                items += len;
            end
            s_valid <= 1'b0;
        end

        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
